@@ design/lzss_pkg.sv @@
// Shared types and constants for the LZSS stream decoder.
// No dependencies; imported by the decoder core.
package lzss_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 5;
    localparam int FIDX_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [BYTE_W-1:0]    FILL_RST  = 8'h00;
    localparam logic [POS_W-1:0]     START_RST = 12'hFEE;
    localparam logic [LEN_W-1:0]     BASE_LEN  = 5'd3;
    localparam logic [FIDX_W-1:0]    FLAG_DONE = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    typedef enum logic [1:0] {
        PH_START,
        PH_FLAG,
        PH_TOKEN,
        PH_MATCH
    } t_phase;

endpackage

@@ design/lzss_stream_decoder_core.sv @@
// LZSS stream decoder core: token parser, history window memory and match copier.
// Depends on lzss_pkg.
//
// Input channel: one compressed byte per word (i_data_byte, i_stream_last), taken
// when i_in_valid is high and o_in_stall is low. Output channel: one decompressed
// byte per word (o_out_byte, o_run_last), taken when o_out_valid is high and
// i_out_stall is low. o_run_last marks the final byte caused by one input word.
// A flag byte or a first match byte gives no output. A literal appears on the output
// register in the cycle after acceptance. A match of N bytes (3 to 18) holds o_in_stall
// until its last byte is in the output register: the window memory read is registered,
// then one byte leaves per cycle while the receiver does not stall, the rate of the
// output register. While a match streams, the memory reads one entry and writes another.
// Unwritten window entries read as the fill byte, tracked by a fill count, so a
// stream start needs no clearing of the window. Configuration writes take effect at the
// next stream start. Reset returns the parser to stream start with fill 0 and
// start position 0xFEE; the output register comes up empty. When the receiver
// stalls, the output word holds and the copier pauses with one byte in hand.
module lzss_stream_decoder_core #(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_stream_last,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_out_byte,
    output logic                              o_run_last,
    input  logic                              i_cfg_we,
    input  logic [lzss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lzss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lzss_pkg::*;

    localparam int AW    = $clog2(WINDOW_SIZE);
    localparam int CNT_W = AW + 1;
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW_SIZE);

    logic [BYTE_W-1:0]  r_fill_cfg;
    logic [POS_W-1:0]   r_start_cfg;
    logic [BYTE_W-1:0]  r_fill_cur;
    logic [AW-1:0]      r_base;
    logic [POS_W-1:0]   r_wp;
    logic [CNT_W-1:0]   r_cnt;
    t_phase             r_phase;
    logic [BYTE_W-1:0]  r_flags;
    logic [FIDX_W-1:0]  r_fidx;
    logic [BYTE_W-1:0]  r_mlow;
    t_state             r_state, n_state;
    logic [AW-1:0]      r_src;
    logic [LEN_W-1:0]   r_left;
    logic               r_pend;
    logic               r_pend_last;
    logic               r_fwd;
    logic [BYTE_W-1:0]  r_fwd_d;
    logic               r_rvalid;
    logic [BYTE_W-1:0]  r_q;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;

    logic [BYTE_W-1:0]  mem [WINDOW_SIZE];

    logic               out_free;
    logic               in_acc;
    logic               lit;
    logic               mstart;
    logic               cons;
    logic               issue;
    logic               wr_en;
    logic [AW-1:0]      wr_idx;
    logic [BYTE_W-1:0]  wr_data;
    logic [BYTE_W-1:0]  d_val;
    logic [AW-1:0]      rel;
    logic               rd_ok;
    logic               fwd_hit;
    logic [FIDX_W-1:0]  fidx_inc;
    t_phase             ph_done;
    logic [POS_W-1:0]   off;

    // ---- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (mstart) n_state = ST_COPY;
            end
            ST_COPY: begin
                if (r_left == '0 && (!r_pend || cons)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- control outputs
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = (r_state != ST_IDLE) || !out_free;
        in_acc     = i_in_valid && !o_in_stall;
        lit        = in_acc && (r_phase == PH_TOKEN) && r_flags[r_fidx[2:0]];
        mstart     = in_acc && (r_phase == PH_MATCH);
        cons       = r_pend && out_free;
        issue      = (r_state == ST_COPY) && (r_left != '0) && (!r_pend || cons);
    end

    always_comb begin
        d_val    = r_fwd ? r_fwd_d : (r_rvalid ? r_q : r_fill_cur);
        wr_en    = cons || lit;
        wr_idx   = r_wp[AW-1:0];
        wr_data  = lit ? i_data_byte : d_val;
        rel      = r_src - r_base;
        rd_ok    = {1'b0, rel} < r_cnt;
        fwd_hit  = cons && (r_src == wr_idx);
        fidx_inc = r_fidx + 1'b1;
        ph_done  = (fidx_inc >= FLAG_DONE) ? PH_FLAG : PH_TOKEN;
        off      = {i_data_byte[7:4], r_mlow};
    end

    // ---- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cfg  <= FILL_RST;
            r_start_cfg <= START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILL:  r_fill_cfg  <= i_cfg_data[BYTE_W-1:0];
                CFG_START: r_start_cfg <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- token parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_flags <= '0;
            r_fidx  <= FLAG_DONE;
            r_mlow  <= '0;
        end else if (in_acc) begin
            if (i_stream_last) begin
                r_phase <= PH_START;
                r_flags <= '0;
                r_fidx  <= FLAG_DONE;
                r_mlow  <= '0;
            end else begin
                case (r_phase)
                    PH_START, PH_FLAG: begin
                        r_flags <= i_data_byte;
                        r_fidx  <= '0;
                        r_phase <= PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        if (r_flags[r_fidx[2:0]]) begin
                            r_fidx  <= fidx_inc;
                            r_phase <= ph_done;
                        end else begin
                            r_mlow  <= i_data_byte;
                            r_phase <= PH_MATCH;
                        end
                    end
                    PH_MATCH: begin
                        r_mlow  <= '0;
                        r_fidx  <= fidx_inc;
                        r_phase <= ph_done;
                    end
                    default: r_phase <= PH_START;
                endcase
            end
        end
    end

    // ---- window position and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= START_RST;
            r_base     <= START_RST[AW-1:0];
            r_cnt      <= '0;
            r_fill_cur <= FILL_RST;
        end else if (in_acc && r_phase == PH_START) begin
            r_wp       <= r_start_cfg;
            r_base     <= r_start_cfg[AW-1:0];
            r_cnt      <= '0;
            r_fill_cur <= r_fill_cfg;
        end else if (wr_en) begin
            r_wp <= r_wp + 1'b1;
            if (r_cnt != WIN_CNT) r_cnt <= r_cnt + 1'b1;
        end
    end

    // ---- match copier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mstart) begin
                r_left <= BASE_LEN + LEN_W'(i_data_byte[3:0]);
            end else if (issue) begin
                r_left <= r_left - 1'b1;
            end
            if (issue) begin
                r_pend      <= 1'b1;
                r_pend_last <= (r_left == LEN_W'(1));
            end else if (cons) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mstart) begin
            r_src <= off[AW-1:0];
        end else if (issue) begin
            r_src <= r_src + 1'b1;
        end
    end

    // ---- window memory; read data held until the next issue
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_idx] <= wr_data;
        if (issue) r_q <= mem[r_src];
    end

    // byte being written this cycle bypasses the memory
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_fwd    <= fwd_hit;
            r_fwd_d  <= d_val;
            r_rvalid <= rd_ok;
        end
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (lit || cons) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lit) begin
            r_out_byte <= i_data_byte;
            r_out_last <= 1'b1;
        end else if (cons) begin
            r_out_byte <= d_val;
            r_out_last <= r_pend_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

@@ design/lzss_chk.sv @@
// Port-level checks for the LZSS stream decoder core, with bind.
// No package dependency; attaches to lzss_stream_decoder_core.
module lzss_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);

    // output register comes up empty
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("stalled output word changed");

    // input is only taken when the output register can accept a new word
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> (!o_out_valid || !i_out_stall))
        else $error("input taken with output register blocked");

    // mid-match bytes keep the input stalled
    a_mid_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> o_in_stall)
        else $error("input taken during a match copy");

endmodule

bind lzss_stream_decoder_core lzss_chk u_lzss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_run_last  (o_run_last)
);

@@ tb/tb_lzss_stream_decoder_core.sv @@
// Self-checking testbench for lzss_stream_decoder_core: a directed table, then random streams.
// Each decoded word is checked against an internal model of the window decoder or typed table words.
// Depends on lzss_pkg and the decoder core.
module tb_lzss_stream_decoder_core;
    import lzss_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_WORDS   = 58;
    localparam int DIR_ROWS      = 24;
    localparam int WIN_DEPTH     = 4096;

    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [BYTE_W-1:0]       data;
        logic                    last;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   val;
        logic [4:0]              typed_n;
        logic [BYTE_W-1:0]       typed_b;
    } t_stim_row;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              last;
    } t_out_word;

    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [BYTE_W-1:0]     in_data   = '0;
    logic                  in_last   = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_FILL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_run_last;

    lzss_stream_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (in_data),
        .i_stream_last (in_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // decoder model state
    logic [BYTE_W-1:0] win_mem [WIN_DEPTH];
    logic [POS_W-1:0]  wpos      = START_RST;
    logic [BYTE_W-1:0] flag_byte = '0;
    logic [FIDX_W-1:0] flag_pos  = FLAG_DONE;
    t_phase            parse_ph  = PH_START;
    logic [BYTE_W-1:0] off_low   = '0;
    logic [BYTE_W-1:0] fill_reg  = FILL_RST;
    logic [POS_W-1:0]  start_reg = START_RST;

    t_out_word   want_q[$];
    t_out_word   got_want;
    t_stim_row   dir_tab [DIR_ROWS];
    int          mismatches  = 0;
    int          quiet_cycles = 0;
    bit          hold_req    = 1'b0;
    bit          gaps_on     = 1'b1;
    logic [3:0]  gen_hi      = '0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // appends one due word at the tail of the queue
    task automatic queue_word(input t_out_word w);
        want_q = {want_q, w};
    endtask

    task automatic advance_token();
        flag_pos = flag_pos + 1'b1;
        parse_ph = (flag_pos >= FLAG_DONE) ? PH_FLAG : PH_TOKEN;
    endtask

    // Steps the model by one compressed byte; queues the decoded words when keep is set.
    task automatic decode_byte(input logic [BYTE_W-1:0] d, input logic l, input bit keep);
        logic [POS_W-1:0]  src;
        logic [BYTE_W-1:0] v;
        int                n;
        if (parse_ph == PH_START) begin
            foreach (win_mem[k]) win_mem[k] = fill_reg;
            wpos = start_reg;
            parse_ph = PH_FLAG;
        end
        case (parse_ph)
            PH_FLAG: begin
                flag_byte = d;
                flag_pos = '0;
                parse_ph = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (flag_byte[flag_pos[2:0]]) begin
                    win_mem[wpos] = d;
                    wpos = wpos + 1'b1;
                    if (keep) queue_word(t_out_word'{d, 1'b1});
                    advance_token();
                end else begin
                    off_low = d;
                    parse_ph = PH_MATCH;
                end
            end
            default: begin
                src = {d[7:4], off_low};
                n = int'(BASE_LEN) + int'(d[3:0]);
                // byte by byte, so an overlapping copy sees what it just wrote
                for (int i = 0; i < n; i++) begin
                    v = win_mem[src];
                    src = src + 1'b1;
                    win_mem[wpos] = v;
                    wpos = wpos + 1'b1;
                    if (keep) queue_word(t_out_word'{v, (i == n - 1)});
                end
                off_low = '0;
                advance_token();
            end
        endcase
        if (l) begin
            parse_ph = PH_START;
            flag_byte = '0;
            flag_pos = FLAG_DONE;
            off_low = '0;
        end
    endtask

    task automatic send_word(input logic [BYTE_W-1:0] d, input logic l,
                             input logic [4:0] typed_n, input logic [BYTE_W-1:0] typed_b);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= d;
        in_last  <= l;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        decode_byte(d, l, typed_n == 0);
        for (int k = 0; k < typed_n; k++)
            queue_word(t_out_word'{typed_b, (k == typed_n - 1)});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        // takes effect at the next stream start
        if (idx == CFG_FILL) fill_reg = val[BYTE_W-1:0];
        else if (idx == CFG_START) start_reg = val[POS_W-1:0];
    endtask

    // Block must be idle before a register write; a flag or first match byte
    // gives no word, hence the extra cycles.
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_out_word w, input bit has_w);
        mismatches++;
        if (mismatches <= 10) begin
            if (has_w)
                $display("%s: want %02h last %0b, got %02h last %0b",
                         what, w.b, w.last, o_out_byte, o_run_last);
            else
                $display("%s: got %02h last %0b", what, o_out_byte, o_run_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid === 1'b1 && out_stall == 1'b0) begin
            if (want_q.size() == 0) begin
                note_mismatch("word with nothing due", '0, 1'b0);
            end else begin
                got_want = want_q.pop_front();
                if (o_out_byte !== got_want.b || o_run_last !== got_want.last)
                    note_mismatch("wrong word", got_want, 1'b1);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)
            || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall runs, plus one long hold-off on request
    initial begin : rx_idle
        int run;
        bit held;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk) out_stall <= 1'b1;
            end else begin
                run = pick_gap();
                repeat (run) @(negedge i_clk) out_stall <= 1'b1;
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
                repeat (run) @(negedge i_clk) out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] d;
        logic              l;
        logic [POS_W-1:0]  off;
        t_stim_row         row;
        dir_tab = '{
            // reset settings: fill 00, start FEE
            '{ROW_WORD, 8'h02, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'h00, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'hF0, 1'b0, '0, '0, 5'd3, 8'h00},  // match over untouched window
            '{ROW_WORD, 8'hFF, 1'b0, '0, '0, 5'd1, 8'hFF},  // literal
            '{ROW_WORD, 8'hFF, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'hFF, 1'b0, '0, '0, 5'd0, 8'h00},  // longest match, wraps the window
            '{ROW_WORD, 8'hF1, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'hF0, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'hA5, 1'b1, '0, '0, 5'd0, 8'h00},  // lone match byte dropped
            '{ROW_CFG,  8'h00, 1'b0, CFG_FILL,   12'h0FF, 5'd0, 8'h00},
            '{ROW_CFG,  8'h00, 1'b0, CFG_START,  12'h000, 5'd0, 8'h00},
            '{ROW_CFG,  8'h00, 1'b0, CFG_UNUSED, 12'hFFF, 5'd0, 8'h00},
            '{ROW_WORD, 8'hFF, 1'b1, '0, '0, 5'd0, 8'h00},  // flag byte ends the stream
            '{ROW_WORD, 8'h01, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'h55, 1'b0, '0, '0, 5'd1, 8'h55},
            '{ROW_WORD, 8'h00, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'h0F, 1'b0, '0, '0, 5'd0, 8'h00},  // overlapping copy
            '{ROW_WORD, 8'h00, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'h80, 1'b0, '0, '0, 5'd3, 8'hFF},  // reads the fill byte
            '{ROW_WORD, 8'h10, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'h00, 1'b1, '0, '0, 5'd0, 8'h00},
            '{ROW_CFG,  8'h00, 1'b0, CFG_START,  12'hFFF, 5'd0, 8'h00},
            '{ROW_WORD, 8'hFF, 1'b0, '0, '0, 5'd0, 8'h00},
            '{ROW_WORD, 8'h00, 1'b1, '0, '0, 5'd1, 8'h00}
        };
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.val);
            end else begin
                send_word(row.data, row.last, row.typed_n, row.typed_b);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            gaps_on = (p != 3);
            write_reg(CFG_FILL, (p == 1) ? 12'h0FF : (p == 2) ? 12'h000
                                         : 12'($urandom_range(0, 255)));
            write_reg(CFG_START, (p == 1) ? 12'h000 : (p == 2) ? 12'hFFF
                                          : 12'($urandom_range(0, 4095)));
            if (p == 3) write_reg(CFG_UNUSED, 12'($urandom));
            if (p == 1) hold_req = 1'b1;
            for (int w = 0; w < PHASE_WORDS; w++) begin
                // shape tokens from the parser state: matches mostly reach recent history
                case (parse_ph)
                    PH_TOKEN: begin
                        if (flag_byte[flag_pos[2:0]]) begin
                            d = 8'($urandom);
                        end else begin
                            if ($urandom_range(0, 9) < 6)
                                off = wpos - 12'($urandom_range(1, 24));
                            else
                                off = 12'($urandom);
                            d = off[7:0];
                            gen_hi = off[11:8];
                        end
                    end
                    PH_MATCH: begin
                        if ($urandom_range(0, 7) == 0) d = 8'($urandom);
                        else d = {gen_hi, 4'($urandom)};
                    end
                    default: d = 8'($urandom);
                endcase
                l = ($urandom_range(0, 29) == 0);
                send_word(d, l, '0, '0);
            end
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && want_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
